// ===== hdl/ezs_pkg.sv =====
`timescale 1ns / 1ps

package ezs_pkg;

   // Fixed-point layout of prices, averages and the derived terms.
   localparam int PRICE_FRAC_BITS = 16;
   localparam int DECAY_BITS      = 16;
   localparam int PRICE_BITS      = 40;
   localparam int AVG_EXTRA       = 8;
   localparam int AVG_BITS        = PRICE_BITS + AVG_EXTRA;
   localparam int DIFF_BITS       = AVG_BITS + 1;
   localparam int NUM_SHIFT       = 8;
   localparam int NUM_BITS        = DIFF_BITS + NUM_SHIFT;
   localparam int DSR_BITS        = PRICE_BITS;
   localparam int W_BITS          = DECAY_BITS + 1;
   localparam int ACC_BITS        = DIFF_BITS + 1;
   localparam int ADD_BITS        = ACC_BITS + 1;
   localparam int PROD_BITS       = ACC_BITS + W_BITS;
   localparam int DELTA_BITS      = DIFF_BITS + 1;
   localparam int CNT_BITS        = $clog2(NUM_BITS + 1);
   localparam int Z_BITS          = 62;
   localparam int ZINF_SHIFT      = 60;
   localparam int SUM_BITS        = Z_BITS + 1;
   localparam int VALUE_BITS      = 32;
   localparam int DECAY_REG_BITS  = 16;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 4;
   localparam int REQ_DATA_BITS   = 88;
   localparam int REQ_USER_BITS   = 3;

   localparam logic [DECAY_REG_BITS-1:0] DECAY_RESET = 16'd62259;

   localparam logic SRC_DEP   = 1'b0;
   localparam logic SRC_INDEP = 1'b1;

   typedef enum logic [1:0] {
      OP_PRICE     = 2'd0,
      OP_STDEV     = 2'd1,
      OP_INTERRUPT = 2'd2,
      OP_RESUME    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_DEP_DECAY   = 2'd0,
      REG_INDEP_DECAY = 2'd1,
      REG_NEGATE      = 2'd2
   } reg_index_type;

   typedef enum logic {
      UNIT_MUL = 1'b0,
      UNIT_DIV = 1'b1
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
   } unit_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_ROUND,
      ST_AVG,
      ST_ZDIFF,
      ST_ZMAG,
      ST_ZDIV,
      ST_SUM,
      ST_EMIT
   } state_type;

endpackage

// ===== hdl/ewma_zscore_spread.sv =====
`timescale 1ns / 1ps
// Channel  Ports      Direction  Item
// req      req_t*     in         operation, source, price, new_stdev, markets_ready
// rsp      rsp_t*     out        indicator_value, from_interrupt
// csr      csr_p*     in/out     dep_decay @0x0, indep_decay @0x4, negate_indep @0x8
//
// A price update that advances an average runs a multiply and two divisions on one
// shared shift/add unit, one division per side; a zero stdev skips its division.
// Other items return to idle after decode, an interruption by way of the emit state.
// Reset is synchronous, active high. req_tready is high only when the sequencer is
// idle; a result that finds the output register still full holds the sequencer, and so
// the input, until it is taken.

module ewma_zscore_spread import ezs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // price [39:0], new_stdev [79:40], markets_ready [80], zero fill above
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // operation [1:0], source [2]
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // indicator_value [31:0]
   output logic [VALUE_BITS-1:0]    rsp_tdata,
   // from_interrupt [0]
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam logic [W_BITS-1:0]    W_ONE      = W_BITS'(1) << DECAY_BITS;
   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (DECAY_BITS - 1);
   localparam logic [PRICE_BITS-1:0] SD_RESET  = PRICE_BITS'(0) - (PRICE_BITS'(1) << PRICE_FRAC_BITS);
   localparam logic [Z_BITS-1:0]    Z_INF      = Z_BITS'(1) << ZINF_SHIFT;
   localparam logic [SUM_BITS-1:0]  SUM_MAX    =
      {{(SUM_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0]  SUM_MIN    =
      {{(SUM_BITS-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

   function automatic logic [DIFF_BITS-1:0] price_gap(input logic [PRICE_BITS-1:0] p,
                                                      input logic [AVG_BITS-1:0] a);
      logic [AVG_BITS-1:0] scaled;
      scaled = {p, {AVG_EXTRA{1'b0}}};
      return {scaled[AVG_BITS-1], scaled} - {a[AVG_BITS-1], a};
   endfunction

   function automatic logic [AVG_BITS-1:0] seed_of(input logic [PRICE_BITS-1:0] p);
      return {p, {AVG_EXTRA{1'b0}}};
   endfunction

   state_type state_ff, state_in;

   op_type                item_op_ff, item_op_in;
   logic                  item_src_ff, item_src_in;
   logic [PRICE_BITS-1:0] item_price_ff, item_price_in;
   logic [PRICE_BITS-1:0] item_sd_ff, item_sd_in;
   logic                  item_ready_ff, item_ready_in;

   logic [PRICE_BITS-1:0] dep_price_ff, dep_price_in, indep_price_ff, indep_price_in;
   logic [AVG_BITS-1:0]   dep_avg_ff, dep_avg_in, indep_avg_ff, indep_avg_in;
   logic [PRICE_BITS-1:0] dep_sd_ff, dep_sd_in, indep_sd_ff, indep_sd_in;
   logic                  started_ff, started_in, frozen_ff, frozen_in;
   logic                  dep_down_ff, dep_down_in, indep_down_ff, indep_down_in;

   logic [DECAY_REG_BITS-1:0] dep_decay_ff, dep_decay_in, indep_decay_ff, indep_decay_in;
   logic                      negate_ff, negate_in;

   logic                  side_ff, side_in;
   logic [DIFF_BITS-1:0]  diff_ff, diff_in;
   logic [DELTA_BITS-1:0] delta_ff, delta_in;
   logic                  zneg_ff, zneg_in;
   logic [Z_BITS-1:0]     zi_ff, zi_in, zd_ff, zd_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;
   logic                  res_intr_ff, res_intr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_intr_ff, rsp_intr_in;

   logic                  req_accept, csr_write, rsp_free, price_run;
   reg_index_type         csr_index;
   logic [DIFF_BITS-1:0]  decode_diff;
   logic [DECAY_REG_BITS-1:0] decode_decay;
   logic [W_BITS-1:0]     decode_weight;
   logic [NUM_BITS-1:0]   num_val, num_mag;
   logic [PRICE_BITS-1:0] zs_sd, sd_mag;
   logic                  sd_zero, zs_negate;
   logic [Z_BITS-1:0]     z_special, z_quot, z_value;
   logic [PROD_BITS-1:0]  rounded;
   logic [SUM_BITS-1:0]   spread;
   logic [VALUE_BITS-1:0] clamped;

   unit_ctrl_type         unit_ctrl;
   logic [NUM_BITS-1:0]   unit_a;
   logic [DSR_BITS-1:0]   unit_b;
   logic                  unit_done;
   logic [PROD_BITS-1:0]  unit_product;
   logic [NUM_BITS-1:0]   unit_quotient;

   ezs_serial_unit u_unit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (unit_ctrl),
      .operand_a (unit_a),
      .operand_b (unit_b),
      .done      (unit_done),
      .product   (unit_product),
      .quotient  (unit_quotient)
   );

   assign req_accept = req_tvalid & req_tready;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign price_run  = (item_op_ff == OP_PRICE) & started_ff & ~frozen_ff;

   // Operands for the shared unit and the z-score terms.
   always_comb begin
      decode_diff   = price_gap(item_price_ff,
                                (item_src_ff == SRC_INDEP) ? indep_avg_ff : dep_avg_ff);
      decode_decay  = (item_src_ff == SRC_INDEP) ? indep_decay_ff : dep_decay_ff;
      decode_weight = W_ONE - {1'b0, DECAY_BITS'(decode_decay)};

      num_val   = {diff_ff, {NUM_SHIFT{1'b0}}};
      num_mag   = diff_ff[DIFF_BITS-1] ? NUM_BITS'(0) - num_val : num_val;
      zs_sd     = (side_ff == SRC_INDEP) ? indep_sd_ff : dep_sd_ff;
      sd_mag    = zs_sd[PRICE_BITS-1] ? PRICE_BITS'(0) - zs_sd : zs_sd;
      sd_zero   = (zs_sd == '0);
      zs_negate = (side_ff == SRC_INDEP) & negate_ff;

      // A zero stdev gives zero over zero, else an infinity of the term's sign.
      if (diff_ff == '0)
         z_special = '0;
      else if (diff_ff[DIFF_BITS-1] ^ zs_negate)
         z_special = Z_BITS'(0) - Z_INF;
      else
         z_special = Z_INF;

      z_quot = Z_BITS'(unit_quotient);
      z_value = zneg_ff ? Z_BITS'(0) - z_quot : z_quot;

      rounded = unit_product + ROUND_HALF;

      spread = {zi_ff[Z_BITS-1], zi_ff} - {zd_ff[Z_BITS-1], zd_ff};
      if ($signed(spread) > $signed(SUM_MAX))
         clamped = SUM_MAX[VALUE_BITS-1:0];
      else if ($signed(spread) < $signed(SUM_MIN))
         clamped = SUM_MIN[VALUE_BITS-1:0];
      else
         clamped = spread[VALUE_BITS-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_DECODE;
         ST_DECODE: begin
            unique case (item_op_ff)
               OP_INTERRUPT: state_in = ST_EMIT;
               OP_PRICE:     state_in = price_run ? ST_MUL : ST_IDLE;
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_MUL:    if (unit_done) state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_AVG;
         ST_AVG:    state_in = ST_ZDIFF;
         ST_ZDIFF:  state_in = ST_ZMAG;
         ST_ZMAG: begin
            if (!sd_zero)
               state_in = ST_ZDIV;
            else
               state_in = (side_ff == SRC_INDEP) ? ST_ZDIFF : ST_SUM;
         end
         ST_ZDIV: begin
            if (unit_done)
               state_in = (side_ff == SRC_INDEP) ? ST_ZDIFF : ST_SUM;
         end
         ST_SUM:    state_in = ST_EMIT;
         ST_EMIT:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      unit_ctrl.start = 1'b0;
      unit_ctrl.mode  = UNIT_MUL;
      unit_a          = '0;
      unit_b          = '0;
      if (state_ff == ST_DECODE && price_run) begin
         unit_ctrl.start = 1'b1;
         unit_ctrl.mode  = UNIT_MUL;
         unit_a          = NUM_BITS'($signed(decode_diff));
         unit_b          = DSR_BITS'(decode_weight);
      end else if (state_ff == ST_ZMAG && !sd_zero) begin
         unit_ctrl.start = 1'b1;
         unit_ctrl.mode  = UNIT_DIV;
         unit_a          = num_mag;
         unit_b          = sd_mag;
      end
   end

   // Datapath and block state.
   always_comb begin
      item_op_in     = item_op_ff;
      item_src_in    = item_src_ff;
      item_price_in  = item_price_ff;
      item_sd_in     = item_sd_ff;
      item_ready_in  = item_ready_ff;
      dep_price_in   = dep_price_ff;
      indep_price_in = indep_price_ff;
      dep_avg_in     = dep_avg_ff;
      indep_avg_in   = indep_avg_ff;
      dep_sd_in      = dep_sd_ff;
      indep_sd_in    = indep_sd_ff;
      started_in     = started_ff;
      frozen_in      = frozen_ff;
      dep_down_in    = dep_down_ff;
      indep_down_in  = indep_down_ff;
      dep_decay_in   = dep_decay_ff;
      indep_decay_in = indep_decay_ff;
      negate_in      = negate_ff;
      side_in        = side_ff;
      diff_in        = diff_ff;
      delta_in       = delta_ff;
      zneg_in        = zneg_ff;
      zi_in          = zi_ff;
      zd_in          = zd_ff;
      res_value_in   = res_value_ff;
      res_intr_in    = res_intr_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_intr_in    = rsp_intr_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;

      if (csr_write) begin
         unique case (csr_index)
            REG_DEP_DECAY:   dep_decay_in   = csr_pwdata[DECAY_REG_BITS-1:0];
            REG_INDEP_DECAY: indep_decay_in = csr_pwdata[DECAY_REG_BITS-1:0];
            REG_NEGATE:      negate_in      = csr_pwdata[0];
            default: ;
         endcase
      end

      if (req_accept) begin
         item_op_in    = op_type'(req_tuser[1:0]);
         item_src_in   = req_tuser[2];
         item_price_in = req_tdata[PRICE_BITS-1:0];
         item_sd_in    = req_tdata[2*PRICE_BITS-1:PRICE_BITS];
         item_ready_in = req_tdata[2*PRICE_BITS];
      end

      unique case (state_ff)
         ST_DECODE: begin
            unique case (item_op_ff)
               OP_STDEV: begin
                  if (item_src_ff == SRC_INDEP) indep_sd_in = item_sd_ff;
                  else                          dep_sd_in   = item_sd_ff;
               end
               OP_INTERRUPT: begin
                  if (item_src_ff == SRC_INDEP) indep_down_in = 1'b1;
                  else                          dep_down_in   = 1'b1;
                  frozen_in    = 1'b1;
                  res_value_in = '0;
                  res_intr_in  = 1'b1;
               end
               OP_RESUME: begin
                  // A resume only counts while frozen; both sides up reseeds.
                  if (frozen_ff) begin
                     if (item_src_ff == SRC_INDEP) indep_down_in = 1'b0;
                     else                          dep_down_in   = 1'b0;
                     if (!dep_down_in && !indep_down_in) begin
                        dep_avg_in   = seed_of(dep_price_ff);
                        indep_avg_in = seed_of(indep_price_ff);
                        frozen_in    = 1'b0;
                     end
                  end
               end
               OP_PRICE: begin
                  if (item_src_ff == SRC_INDEP) indep_price_in = item_price_ff;
                  else                          dep_price_in   = item_price_ff;
                  if (!started_ff && item_ready_ff) begin
                     started_in   = 1'b1;
                     dep_avg_in   = seed_of(dep_price_in);
                     indep_avg_in = seed_of(indep_price_in);
                  end
               end
               default: ;
            endcase
         end
         ST_ROUND: delta_in = rounded[DECAY_BITS +: DELTA_BITS];
         ST_AVG: begin
            if (item_src_ff == SRC_INDEP)
               indep_avg_in = indep_avg_ff + delta_ff[AVG_BITS-1:0];
            else
               dep_avg_in = dep_avg_ff + delta_ff[AVG_BITS-1:0];
            side_in = SRC_INDEP;
         end
         ST_ZDIFF: begin
            if (side_ff == SRC_INDEP)
               diff_in = price_gap(indep_price_ff, indep_avg_ff);
            else
               diff_in = price_gap(dep_price_ff, dep_avg_ff);
         end
         ST_ZMAG: begin
            zneg_in = diff_ff[DIFF_BITS-1] ^ zs_sd[PRICE_BITS-1] ^ zs_negate;
            if (sd_zero) begin
               if (side_ff == SRC_INDEP) zi_in = z_special;
               else                      zd_in = z_special;
               side_in = SRC_DEP;
            end
         end
         ST_ZDIV: begin
            if (unit_done) begin
               if (side_ff == SRC_INDEP) zi_in = z_value;
               else                      zd_in = z_value;
               side_in = SRC_DEP;
            end
         end
         ST_SUM: begin
            res_value_in = clamped;
            res_intr_in  = 1'b0;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_intr_in  = res_intr_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         dep_price_ff   <= '0;
         indep_price_ff <= '0;
         dep_avg_ff     <= '0;
         indep_avg_ff   <= '0;
         dep_sd_ff      <= SD_RESET;
         indep_sd_ff    <= SD_RESET;
         started_ff     <= 1'b0;
         frozen_ff      <= 1'b0;
         dep_down_ff    <= 1'b0;
         indep_down_ff  <= 1'b0;
         dep_decay_ff   <= DECAY_RESET;
         indep_decay_ff <= DECAY_RESET;
         negate_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         dep_price_ff   <= dep_price_in;
         indep_price_ff <= indep_price_in;
         dep_avg_ff     <= dep_avg_in;
         indep_avg_ff   <= indep_avg_in;
         dep_sd_ff      <= dep_sd_in;
         indep_sd_ff    <= indep_sd_in;
         started_ff     <= started_in;
         frozen_ff      <= frozen_in;
         dep_down_ff    <= dep_down_in;
         indep_down_ff  <= indep_down_in;
         dep_decay_ff   <= dep_decay_in;
         indep_decay_ff <= indep_decay_in;
         negate_ff      <= negate_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      item_op_ff    <= item_op_in;
      item_src_ff   <= item_src_in;
      item_price_ff <= item_price_in;
      item_sd_ff    <= item_sd_in;
      item_ready_ff <= item_ready_in;
      side_ff       <= side_in;
      diff_ff       <= diff_in;
      delta_ff      <= delta_in;
      zneg_ff       <= zneg_in;
      zi_ff         <= zi_in;
      zd_ff         <= zd_in;
      res_value_ff  <= res_value_in;
      res_intr_ff   <= res_intr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_intr_ff   <= rsp_intr_in;
   end

   always_comb begin
      unique case (csr_index)
         REG_DEP_DECAY:   csr_prdata = CSR_DATA_BITS'(dep_decay_ff);
         REG_INDEP_DECAY: csr_prdata = CSR_DATA_BITS'(indep_decay_ff);
         REG_NEGATE:      csr_prdata = CSR_DATA_BITS'(negate_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_intr_ff;

endmodule

// ===== hdl/ezs_serial_unit.sv =====
`timescale 1ns / 1ps

module ezs_serial_unit import ezs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  unit_ctrl_type        ctrl,
   input  logic [NUM_BITS-1:0]  operand_a,
   input  logic [DSR_BITS-1:0]  operand_b,
   output logic                 done,
   output logic [PROD_BITS-1:0] product,
   output logic [NUM_BITS-1:0]  quotient
);

   unit_mode_type        mode_ff, mode_in;
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [ACC_BITS-1:0]  hi_ff, hi_in;
   logic [NUM_BITS-1:0]  lo_ff, lo_in;
   logic [DIFF_BITS-1:0] mcand_ff, mcand_in;
   logic [DSR_BITS-1:0]  dsr_ff, dsr_in;

   logic [ADD_BITS-1:0]  add_a, add_b, add_sum;
   logic                 add_cin;
   logic                 trial_ok;
   logic [ACC_BITS-1:0]  hi_step;
   logic [NUM_BITS-1:0]  lo_step;

   // The one adder: accumulate for the multiply, trial subtract for the divide.
   always_comb begin
      unique case (mode_ff)
         UNIT_MUL: begin
            add_a   = {hi_ff[ACC_BITS-1], hi_ff};
            add_b   = lo_ff[0] ? {{(ADD_BITS-DIFF_BITS){mcand_ff[DIFF_BITS-1]}}, mcand_ff}
                               : '0;
            add_cin = 1'b0;
         end
         UNIT_DIV: begin
            add_a   = ADD_BITS'({hi_ff[DSR_BITS-1:0], lo_ff[NUM_BITS-1]});
            add_b   = ~ADD_BITS'(dsr_ff);
            add_cin = 1'b1;
         end
         default: begin
            add_a   = '0;
            add_b   = '0;
            add_cin = 1'b0;
         end
      endcase
      add_sum  = add_a + add_b + ADD_BITS'(add_cin);
      trial_ok = ~add_sum[ADD_BITS-1];
   end

   always_comb begin
      unique case (mode_ff)
         UNIT_MUL: begin
            // Arithmetic shift right of the partial product; its low bit joins the
            // multiplier register as the multiplier bits drain out.
            hi_step = {add_sum[ACC_BITS-1], add_sum[ACC_BITS-1:1]};
            lo_step = (lo_ff >> 1) | (NUM_BITS'(add_sum[0]) << (W_BITS - 1));
         end
         UNIT_DIV: begin
            hi_step = trial_ok ? ACC_BITS'(add_sum[DSR_BITS-1:0])
                               : ACC_BITS'(add_a[DSR_BITS-1:0]);
            lo_step = {lo_ff[NUM_BITS-2:0], trial_ok};
         end
         default: begin
            hi_step = hi_ff;
            lo_step = lo_ff;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      mcand_in  = mcand_ff;
      dsr_in    = dsr_ff;
      if (ctrl.start) begin
         mode_in   = ctrl.mode;
         active_in = 1'b1;
         hi_in     = '0;
         mcand_in  = operand_a[DIFF_BITS-1:0];
         dsr_in    = operand_b;
         if (ctrl.mode == UNIT_MUL) begin
            lo_in    = NUM_BITS'(operand_b[W_BITS-1:0]);
            count_in = CNT_BITS'(W_BITS);
         end else begin
            lo_in    = operand_a;
            count_in = CNT_BITS'(NUM_BITS);
         end
      end else if (active_ff) begin
         hi_in    = hi_step;
         lo_in    = lo_step;
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      mode_ff  <= mode_in;
      count_ff <= count_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
      dsr_ff   <= dsr_in;
   end

   assign done     = done_ff;
   assign product  = {hi_ff, lo_ff[W_BITS-1:0]};
   assign quotient = lo_ff;

endmodule

// ===== tb/ewma_zscore_spread_tb.sv =====
`timescale 1ns / 1ps

module ewma_zscore_spread_tb import ezs_pkg::*; ();

   localparam int     SETTLE_CYCLES = 200;
   localparam int     HOLD_CYCLES   = 600;
   localparam longint Z_LIMIT       = 64'sd1 <<< ZINF_SHIFT;
   localparam longint SUM_MAX       = 64'sd2147483647;
   localparam longint SUM_MIN       = -64'sd2147483648;
   localparam longint PX_BASE       = 64'sd6553600;
   localparam logic signed [PRICE_BITS-1:0] PX_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [PRICE_BITS-1:0] PX_MIN = 40'sh80_0000_0000;
   localparam logic signed [PRICE_BITS-1:0] PX_ONE = 40'sd65536;

   typedef struct packed {
      op_type                       op;
      logic                         source;
      logic signed [PRICE_BITS-1:0] price;
      logic signed [PRICE_BITS-1:0] stdev;
      logic                         ready;
   } market_req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  from_interrupt;
   } spread_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // price [39:0], new_stdev [79:40], markets_ready [80], zero fill above
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   // operation [1:0], source [2]
   logic [REQ_USER_BITS-1:0] req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // indicator_value [31:0]
   logic [VALUE_BITS-1:0]    rsp_tdata;
   // from_interrupt [0]
   logic                     rsp_tuser;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   ewma_zscore_spread u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block's registers and market state.
   logic [DECAY_REG_BITS-1:0]    dep_decay_cfg   = DECAY_RESET;
   logic [DECAY_REG_BITS-1:0]    indep_decay_cfg = DECAY_RESET;
   logic                         negate_cfg      = 1'b0;
   logic signed [PRICE_BITS-1:0] dep_px   = '0;
   logic signed [PRICE_BITS-1:0] indep_px = '0;
   logic signed [AVG_BITS-1:0]   dep_avg   = '0;
   logic signed [AVG_BITS-1:0]   indep_avg = '0;
   logic signed [PRICE_BITS-1:0] dep_sd   = -40'sd65536;
   logic signed [PRICE_BITS-1:0] indep_sd = -40'sd65536;
   logic                         started    = 1'b0;
   logic                         dep_down   = 1'b0;
   logic                         indep_down = 1'b0;
   logic                         frozen     = 1'b0;

   market_req_type    req_queue[$];
   spread_result_type spread_expected[$];
   market_req_type    offered;
   int           mismatches = 0;
   int           gap_left   = 0;
   int           stall_left = 0;
   int           hold_left  = 0;
   logic         src_idle   = 1'b1;
   logic         sink_idle  = 1'b1;
   logic [3:0]   hold_token = '0;
   logic [3:0]   hold_seen  = '0;

   function automatic market_req_type market_item(input op_type op, input logic src,
                                                  input logic signed [PRICE_BITS-1:0] px,
                                                  input logic signed [PRICE_BITS-1:0] sd,
                                                  input logic rdy);
      market_req_type it;
      it.op     = op;
      it.source = src;
      it.price  = px;
      it.stdev  = sd;
      it.ready  = rdy;
      return it;
   endfunction

   function automatic void reseed();
      dep_avg   = AVG_BITS'(longint'(dep_px) * 256);
      indep_avg = AVG_BITS'(longint'(indep_px) * 256);
   endfunction

   // The new sample weighs (2^16 - decay) / 2^16; the step is rounded half up.
   function automatic logic signed [AVG_BITS-1:0] ewma_step(
         input logic signed [AVG_BITS-1:0] avg, input logic signed [PRICE_BITS-1:0] px,
         input logic [DECAY_REG_BITS-1:0] decay);
      logic signed [79:0] diff_w;
      logic signed [79:0] weight_w;
      logic signed [79:0] delta;
      diff_w   = longint'(px) * 256 - longint'(avg);
      weight_w = 80'sd65536 - $signed({64'd0, decay});
      delta    = (diff_w * weight_w + 80'sd32768) >>> DECAY_BITS;
      return avg + AVG_BITS'(delta);
   endfunction

   function automatic longint z_term(input logic signed [PRICE_BITS-1:0] px,
                                     input logic signed [AVG_BITS-1:0] avg,
                                     input logic signed [PRICE_BITS-1:0] sd);
      longint num;
      num = (longint'(px) * 256 - longint'(avg)) * 256;
      if (sd == '0) begin
         if (num == 0)
            return 0;
         return (num > 0) ? Z_LIMIT : -Z_LIMIT;
      end
      return num / longint'(sd);
   endfunction

   // Applies one accepted item to the shadow state; returns 1 when it yields a result.
   function automatic bit predict_spread(input market_req_type it,
                                         output spread_result_type res);
      longint zi;
      longint zd;
      longint sum;
      res = '0;
      case (it.op)
         OP_STDEV: begin
            if (it.source == SRC_INDEP)
               indep_sd = it.stdev;
            else
               dep_sd = it.stdev;
            return 0;
         end
         OP_INTERRUPT: begin
            if (it.source == SRC_INDEP)
               indep_down = 1'b1;
            else
               dep_down = 1'b1;
            frozen = 1'b1;
            res.from_interrupt = 1'b1;
            return 1;
         end
         OP_RESUME: begin
            if (frozen) begin
               if (it.source == SRC_INDEP)
                  indep_down = 1'b0;
               else
                  dep_down = 1'b0;
               if (!dep_down && !indep_down) begin
                  reseed();
                  frozen = 1'b0;
               end
            end
            return 0;
         end
         default: ;
      endcase
      if (it.source == SRC_INDEP)
         indep_px = it.price;
      else
         dep_px = it.price;
      if (!started) begin
         if (it.ready) begin
            started = 1'b1;
            reseed();
         end
         return 0;
      end
      if (frozen)
         return 0;
      if (it.source == SRC_INDEP)
         indep_avg = ewma_step(indep_avg, indep_px, indep_decay_cfg);
      else
         dep_avg = ewma_step(dep_avg, dep_px, dep_decay_cfg);
      zi = z_term(indep_px, indep_avg, indep_sd);
      zd = z_term(dep_px, dep_avg, dep_sd);
      if (negate_cfg)
         zi = -zi;
      sum = zi - zd;
      if (sum > SUM_MAX)
         sum = SUM_MAX;
      else if (sum < SUM_MIN)
         sum = SUM_MIN;
      res.value = sum[VALUE_BITS-1:0];
      return 1;
   endfunction

   always @(posedge clock) begin : req_drive
      spread_result_type res;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (predict_spread(offered, res))
               spread_expected.push_back(res);
         end
         // A refused offer stays on the bus unchanged.
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (req_queue.size() > 0 && src_idle && $urandom_range(0, 5) == 0) begin
               gap_left   <= $urandom_range(0, 14);
               req_tvalid <= 1'b0;
            end else if (req_queue.size() > 0) begin
               offered = req_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, offered.ready, offered.stdev, offered.price};
               req_tuser  <= {offered.source, offered.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      spread_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (spread_expected.size() == 0) begin
               $error("unexpected item: indicator_value %0d from_interrupt %0b",
                      $signed(rsp_tdata), rsp_tuser);
               mismatches++;
            end else begin
               want = spread_expected.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("indicator_value: expected %0d, got %0d",
                         $signed(want.value), $signed(rsp_tdata));
                  mismatches++;
               end
               if (rsp_tuser !== want.from_interrupt) begin
                  $error("from_interrupt: expected %0b, got %0b", want.from_interrupt, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      logic [CSR_DATA_BITS-1:0] keep;
      // Bits above the register's width carry noise; the block must ignore them.
      keep = (idx == REG_NEGATE) ? 32'h1 : 32'hFFFF;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= (val & keep) | ($urandom() & ~keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DEP_DECAY:   dep_decay_cfg = val[DECAY_REG_BITS-1:0];
         REG_INDEP_DECAY: indep_decay_cfg = val[DECAY_REG_BITS-1:0];
         default:         negate_cfg = val[0];
      endcase
   endtask

   task automatic wait_quiet();
      while (req_queue.size() != 0 || req_tvalid || spread_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count, input logic src_gaps, input logic sink_gaps);
      market_req_type it;
      int unsigned    pick;
      src_idle  <= src_gaps;
      sink_idle <= sink_gaps;
      repeat (count) begin
         it.price  = PRICE_BITS'({$urandom(), $urandom()});
         it.stdev  = PRICE_BITS'({$urandom(), $urandom()});
         it.ready  = 1'($urandom_range(0, 1));
         it.source = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            it.op = OP_PRICE;
            case ($urandom_range(0, 9))
               0:       ;
               1:       it.price = $urandom_range(0, 1) ? PX_MAX : PX_MIN;
               2:       it.price = '0;
               3:       it.price = PRICE_BITS'(-PX_BASE / 2
                                               + longint'($urandom_range(0, 2097152)) - 1048576);
               default: it.price = PRICE_BITS'(PX_BASE
                                               + longint'($urandom_range(0, 2097152)) - 1048576);
            endcase
         end else if (pick < 80) begin
            it.op = OP_STDEV;
            case ($urandom_range(0, 9))
               0:       ;
               1:       it.stdev = '0;
               2:       it.stdev = PRICE_BITS'(-longint'($urandom_range(4096, 4194304)));
               default: it.stdev = PRICE_BITS'(longint'($urandom_range(4096, 4194304)));
            endcase
         end else if (pick < 88) begin
            it.op = OP_INTERRUPT;
         end else begin
            it.op = OP_RESUME;
         end
         req_queue.push_back(it);
      end
      wait_quiet();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Before start: interruption, latching, resume and the starting price.
      req_queue.push_back(market_item(OP_INTERRUPT, SRC_DEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, PX_ONE, '0, 1'b0));
      req_queue.push_back(market_item(OP_RESUME, SRC_DEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_RESUME, SRC_INDEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_INDEP, PX_MAX, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, PX_MIN, '0, 1'b1));
      // Running on the reset stdev of minus one, with saturation both ways.
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, PX_MIN, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_INDEP, PX_MIN, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_INDEP, PX_MAX, '0, 1'b0));
      // Zero stdev on both sides: cancelling and saturating infinite terms; then extreme stdevs.
      req_queue.push_back(market_item(OP_STDEV, SRC_INDEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_STDEV, SRC_DEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, PX_MIN, '0, 1'b0));
      req_queue.push_back(market_item(OP_STDEV, SRC_INDEP, '0, PX_MAX, 1'b0));
      req_queue.push_back(market_item(OP_STDEV, SRC_DEP, '0, PX_MIN, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_INDEP, 40'sd12345678, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, -40'sd777777, '0, 1'b0));
      // Freeze from both sides, latch while frozen, then resume in turn.
      req_queue.push_back(market_item(OP_INTERRUPT, SRC_INDEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_INDEP, 40'sd327680, '0, 1'b1));
      req_queue.push_back(market_item(OP_INTERRUPT, SRC_DEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_RESUME, SRC_INDEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_RESUME, SRC_DEP, '0, '0, 1'b0));
      req_queue.push_back(market_item(OP_STDEV, SRC_DEP, '0, PX_ONE, 1'b0));
      req_queue.push_back(market_item(OP_STDEV, SRC_INDEP, '0, -40'sd196608, 1'b0));
      req_queue.push_back(market_item(OP_PRICE, SRC_DEP, 40'sd163840, '0, 1'b0));
      wait_quiet();

      csr_write(REG_DEP_DECAY, 32'd0);
      csr_write(REG_INDEP_DECAY, 32'hFFFF);
      csr_write(REG_NEGATE, 32'd1);
      // The sink holds off for a long while so that the block backs up.
      hold_token <= hold_token + 1'b1;
      run_random(165, 1'b1, 1'b1);

      csr_write(REG_DEP_DECAY, 32'hFFFF);
      csr_write(REG_INDEP_DECAY, 32'd0);
      csr_write(REG_NEGATE, 32'd0);
      run_random(165, 1'b1, 1'b1);

      csr_write(REG_DEP_DECAY, $urandom());
      csr_write(REG_INDEP_DECAY, $urandom());
      csr_write(REG_NEGATE, $urandom());
      run_random(165, 1'b0, 1'b0);

      csr_write(REG_DEP_DECAY, 32'd1);
      csr_write(REG_INDEP_DECAY, 32'd32768);
      csr_write(REG_NEGATE, 32'd1);
      run_random(165, 1'b1, 1'b1);

      csr_write(REG_DEP_DECAY, $urandom());
      csr_write(REG_INDEP_DECAY, $urandom());
      csr_write(REG_NEGATE, 32'd0);
      run_random(165, 1'b0, 1'b0);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ezs_pkg.sv
hdl/ezs_serial_unit.sv
hdl/ewma_zscore_spread.sv
tb/ewma_zscore_spread_tb.sv
